// ===== hdl/msadpcm_pkg.sv =====
// Package: shared types and constants of the ADPCM block decoder.
package msadpcm_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT     = 2'd0,
    REG_BLOCK_BYTES       = 2'd1,
    REG_SAMPLES_PER_BLOCK = 2'd2,
    REG_COEFF_COUNT       = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD_COEFF = 1'b0,
    OP_DATA_BYTE  = 1'b1
  } op_t;

  typedef struct packed {
    logic               op;
    logic        [7:0]  data_byte;
    logic        [4:0]  coeff_index;
    logic signed [15:0] coeff_first;
    logic signed [15:0] coeff_second;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic               last;
    logic               block_done;
    logic               bad_index;
  } out_item_t;

  // Job handed from the byte parser to the sample engine.
  typedef enum logic [1:0] {
    JOB_EMIT   = 2'd0,  // emit header sample
    JOB_DECODE = 2'd1,  // decode one nibble
    JOB_NONE   = 2'd2   // marker carrying only last/done
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic               channel;
    logic        [3:0]  nibble;
    logic signed [15:0] value;
    logic               last;
    logic               block_done;
    logic               bad_index;
  } job_t;

  localparam logic signed [15:0] SAT_MAX = 16'sd32767;
  localparam logic signed [15:0] SAT_MIN = -16'sd32768;
  localparam logic [15:0] DELTA_MIN = 16'd16;

  function automatic logic [9:0] adapt_lookup(input logic [3:0] code);
    logic [9:0] r;
    unique case (code)
      4'd4:  r = 10'd307;
      4'd5:  r = 10'd409;
      4'd6:  r = 10'd512;
      4'd7:  r = 10'd614;
      4'd8:  r = 10'd768;
      4'd9:  r = 10'd614;
      4'd10: r = 10'd512;
      4'd11: r = 10'd409;
      4'd12: r = 10'd307;
      default: r = 10'd230;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ms_adpcm_block_decoder_top.sv =====
// Top level of the ADPCM block decoder.
// Usage:
//   Input queue (in_push/in_full): op 0 loads a coefficient pair into the
//   table, op 1 carries one encoded byte. A transaction is taken when in_push
//   is high and in_full low.
//   Result queue (out_empty/out_pop): the oldest decoded sample sits on
//   out_data while out_empty is low; out_pop takes it.
//   Configuration (cfg_valid/cfg_ready): register index and data, written
//   only while the block is idle; the user must ensure that, as the block
//   has no check for it. cfg_ready is always high.
// Flow:
//   One transaction at a time: in_full stays high until parser, job queue
//   and sample engine are empty. The parser splits a data byte into nibble
//   jobs; the engine handles each decoded nibble with a table read, three
//   passes of the shared 17x17 multiplier and a result. A header byte with
//   a sample goes to the engine as a ready sample; other header bytes and
//   coefficient loads need no work in the engine.
// Reset: rst_n (synchronous, low) clears block position, header state,
//   history and queues; the coefficient table holds garbage until loaded.
// Stall: when out_pop stays low the engine waits with its next result and
//   in_full stays high; no transaction is lost.
module ms_adpcm_block_decoder_top #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned MAX_BLOCK   = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  msadpcm_pkg::in_item_t  in_data,
  output logic                   in_full,
  output logic                   out_empty,
  input  logic                   out_pop,
  output msadpcm_pkg::out_item_t out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [msadpcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_wdata
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [1:0]  channel_count_r;
  logic [12:0] block_bytes_r;
  logic [13:0] samples_per_block_r;
  logic [5:0]  coeff_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r     <= 2'd1;
      block_bytes_r       <= 13'd256;
      samples_per_block_r <= 14'd500;
      coeff_count_r       <= 6'd7;
    end else if (cfg_valid) begin
      unique case (msadpcm_pkg::cfg_reg_t'(cfg_index))
        msadpcm_pkg::REG_CHANNEL_COUNT:     channel_count_r     <= cfg_wdata[1:0];
        msadpcm_pkg::REG_BLOCK_BYTES:       block_bytes_r       <= cfg_wdata[12:0];
        msadpcm_pkg::REG_SAMPLES_PER_BLOCK: samples_per_block_r <= cfg_wdata[13:0];
        msadpcm_pkg::REG_COEFF_COUNT:       coeff_count_r       <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  logic          coef_we;
  logic [AW-1:0] coef_waddr, coef_raddr;
  logic [15:0]   c1, c2;
  logic [4:0]    sel0, sel1;
  logic [15:0]   hdr_delta;
  logic          hdr_delta_we, hdr_ch, hdr_h1_we, hdr_h2_we;
  logic          job_push, job_full, job_pop, job_empty;
  msadpcm_pkg::job_t job_w, job_q;
  logic          fe_full;
  logic          ov;
  logic          engine_idle;
  logic          stall_in;

  // Header writes, table writes and selector changes must not overtake
  // jobs still in flight: take input only once the engine has drained.
  assign stall_in = !job_empty || !engine_idle;
  assign in_full  = fe_full || stall_in;

  msadpcm_front #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk, .rst_n,
    .in_push(in_push && !stall_in), .in_data, .in_full(fe_full),
    .channel_count(channel_count_r), .block_bytes(block_bytes_r),
    .samples_per_block(samples_per_block_r), .coeff_count(coeff_count_r),
    .coef_we, .coef_waddr, .sel0, .sel1,
    .hdr_delta, .hdr_delta_we, .hdr_ch, .hdr_h1_we, .hdr_h2_we,
    .job_push, .job_data(job_w), .job_full
  );

  msadpcm_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_c1 (
    .clk, .we(coef_we), .waddr(coef_waddr), .wdata(in_data.coeff_first),
    .raddr(coef_raddr), .rdata(c1));
  msadpcm_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_c2 (
    .clk, .we(coef_we), .waddr(coef_waddr), .wdata(in_data.coeff_second),
    .raddr(coef_raddr), .rdata(c2));

  msadpcm_fifo #(.DEPTH(4)) u_q (
    .clk, .rst_n, .push(job_push), .wdata(job_w), .full(job_full),
    .pop(job_pop), .rdata(job_q), .empty(job_empty));

  msadpcm_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .job_empty, .job(job_q), .job_pop, .engine_idle,
    .sel0, .sel1, .coef_raddr, .coef1(c1), .coef2(c2),
    .hdr_delta, .hdr_delta_we, .hdr_ch, .hdr_h1_we, .hdr_h2_we,
    .hdr_value(hdr_delta),
    .out_valid(ov), .out_data, .out_take(out_pop && ov));

  assign out_empty = !ov;
endmodule

// ===== hdl/msadpcm_ram.sv =====
// Generic single-port-write RAM with registered read.
module msadpcm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/msadpcm_fifo.sv =====
// Small job queue between parser and sample engine.
module msadpcm_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  msadpcm_pkg::job_t   wdata,
  output logic                full,
  input  logic                pop,
  output msadpcm_pkg::job_t   rdata,
  output logic                empty
);
  localparam int unsigned AW = $clog2(DEPTH);

  msadpcm_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop && !empty) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end
endmodule

// ===== hdl/msadpcm_front.sv =====
// Byte parser: block framing, header capture, job generation.
module msadpcm_front #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned MAX_BLOCK   = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  msadpcm_pkg::in_item_t in_data,
  output logic                  in_full,
  input  logic [1:0]            channel_count,
  input  logic [12:0]           block_bytes,
  input  logic [13:0]           samples_per_block,
  input  logic [5:0]            coeff_count,
  // coefficient write
  output logic                         coef_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] coef_waddr,
  // predictor selections (per channel)
  output logic [4:0]            sel0,
  output logic [4:0]            sel1,
  output logic [15:0]           hdr_delta,
  output logic                  hdr_delta_we,
  output logic                  hdr_ch,
  output logic                  hdr_h1_we,
  output logic                  hdr_h2_we,
  // job queue write side
  output logic                  job_push,
  output msadpcm_pkg::job_t     job_data,
  input  logic                  job_full
);
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FIRST = 3'b010,
    ST_SECOND= 3'b100
  } st_t;

  st_t st_r, st_nxt;
  logic [7:0]  byte_r;
  logic [12:0] pos_r;
  logic [13:0] done_r;
  logic [7:0]  low_r;
  logic        nch_r;  // current nibble channel
  logic [4:0]  sel_r [2];
  logic        bad_r [2];

  logic        stereo;
  logic [13:0] len;
  logic [12:0] pos_k;
  logic [2:0]  w;
  logic [1:0]  grp;
  logic        cw;
  logic [6:0]  cnt;
  logic        end_blk;
  logic        in_hdr_sel, in_hdr_val;
  logic        take;

  assign stereo = channel_count[1];
  always_comb begin
    len = (block_bytes > 13'(MAX_BLOCK > 8191 ? 8191 : MAX_BLOCK))
          ? 14'(MAX_BLOCK) : {1'b0, block_bytes};
    if (len == '0) len = 14'd1;
  end
  assign end_blk = ({1'b0, pos_r} + 14'd1 >= len);
  assign in_hdr_sel = stereo ? (pos_r < 13'd2) : (pos_r < 13'd1);
  assign in_hdr_val = stereo ? (pos_r < 13'd14) : (pos_r < 13'd7);
  assign pos_k = pos_r - (stereo ? 13'd2 : 13'd1);
  // k / (2*nch) and k % (2*nch), k < 12
  always_comb begin
    if (stereo) begin
      grp = pos_k[3:2];
      w   = {1'b0, pos_k[1:0]};
    end else begin
      grp = pos_k[2:1];
      w   = {2'b0, pos_k[0]};
    end
    cw = w[1];
  end
  always_comb begin
    cnt = {1'b0, coeff_count};
    if (cnt > 7'(TABLE_DEPTH)) cnt = 7'(TABLE_DEPTH);
    if (cnt > 7'd32) cnt = 7'd32;
  end

  assign in_full = (st_r != ST_IDLE);
  assign take    = in_push && !in_full;
  assign coef_we = take && (in_data.op == msadpcm_pkg::OP_LOAD_COEFF)
                   && ({3'b0, in_data.coeff_index} < 8'(TABLE_DEPTH < 32 ? TABLE_DEPTH : 32));
  assign coef_waddr = $clog2(TABLE_DEPTH)'(in_data.coeff_index);
  assign sel0 = sel_r[0];
  assign sel1 = sel_r[1];

  // nibble stage helpers
  logic        cur_ch;
  logic        skip;
  logic        fin_cnt;
  logic [13:0] done_inc;
  logic [3:0]  nib;
  logic        last_nib;
  logic        nxt_ch;
  logic [13:0] nxt_done;
  logic        skip_low;
  logic        last_res;
  always_comb begin
    cur_ch   = stereo ? nch_r : 1'b0;
    skip     = !cur_ch && (done_r >= samples_per_block);
    done_inc = (done_r < 14'h3FFF) ? done_r + 14'd1 : done_r;
    fin_cnt  = (cur_ch == stereo) && (done_inc >= samples_per_block);
    nib      = (st_r == ST_FIRST) ? byte_r[7:4] : byte_r[3:0];
    last_nib = (st_r == ST_SECOND);
    // low nibble is dropped when the high one completes the frame count
    nxt_ch   = stereo ? ~cur_ch : 1'b0;
    nxt_done = (cur_ch == stereo) ? done_inc : done_r;
    skip_low = !nxt_ch && (nxt_done >= samples_per_block);
    last_res = last_nib || skip_low;
  end

  // header value path
  logic [15:0] hval;
  assign hval = {in_data.data_byte, low_r};

  always_comb begin
    st_nxt       = st_r;
    job_push     = 1'b0;
    job_data     = '0;
    job_data.kind= msadpcm_pkg::JOB_NONE;
    hdr_delta    = hval;
    hdr_ch       = cw;
    hdr_delta_we = 1'b0;
    hdr_h1_we    = 1'b0;
    hdr_h2_we    = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (take && in_data.op == msadpcm_pkg::OP_DATA_BYTE && !in_hdr_sel
            && in_hdr_val && w[0]) begin
          // header word: needs a queue slot when it emits
          if (grp == 2'd0) begin
            hdr_delta_we = 1'b1;
          end else begin
            hdr_h1_we = (grp == 2'd1);
            hdr_h2_we = (grp == 2'd2);
            job_push  = 1'b1;
            job_data.kind       = msadpcm_pkg::JOB_EMIT;
            job_data.value      = hval;
            job_data.channel    = cw;
            job_data.last       = 1'b1;
            job_data.bad_index  = bad_r[cw];
            job_data.block_done = end_blk || ((cw == stereo) && grp == 2'd2
                                  && samples_per_block <= 14'd2);
          end
        end else if (take && in_data.op == msadpcm_pkg::OP_DATA_BYTE
                     && !in_hdr_val) begin
          st_nxt = ST_FIRST;
        end
      end
      ST_FIRST, ST_SECOND: begin
        if (skip) begin
          // past the frame count: no result for this nibble
          st_nxt = last_nib ? ST_IDLE : ST_SECOND;
        end else begin
          job_push = !job_full;
          job_data.kind       = msadpcm_pkg::JOB_DECODE;
          job_data.nibble     = nib;
          job_data.channel    = cur_ch;
          job_data.bad_index  = bad_r[cur_ch];
          job_data.last       = last_res;
          job_data.block_done = fin_cnt || (last_res && end_blk);
          if (!job_full) st_nxt = last_res ? ST_IDLE : ST_SECOND;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Input is held off in the top level until the engine has drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      pos_r  <= '0;
      done_r <= '0;
      low_r  <= '0;
      nch_r  <= 1'b0;
      sel_r[0] <= '0;
      sel_r[1] <= '0;
      bad_r[0] <= 1'b0;
      bad_r[1] <= 1'b0;
      byte_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE && take && in_data.op == msadpcm_pkg::OP_DATA_BYTE) begin
        byte_r <= in_data.data_byte;
        if (in_hdr_sel) begin
          if ({1'b0, in_data.data_byte} < {1'b0, cnt[5:0], 2'b0} >> 2 &&
              {1'b0, in_data.data_byte} < 9'(cnt)) begin
            sel_r[pos_r[0]] <= in_data.data_byte[4:0];
            bad_r[pos_r[0]] <= 1'b0;
          end else begin
            sel_r[pos_r[0]] <= '0;
            bad_r[pos_r[0]] <= 1'b1;
          end
        end else if (in_hdr_val) begin
          if (!w[0]) low_r <= in_data.data_byte;
          else if (grp != 2'd0 && cw == stereo && !end_blk) done_r <= {12'b0, grp};
        end
        if (in_hdr_val) begin
          if (end_blk) begin
            pos_r  <= '0;
            done_r <= '0;
            nch_r  <= 1'b0;
          end else begin
            pos_r <= pos_r + 13'd1;
          end
        end
      end else if (st_r != ST_IDLE) begin
        if (!skip && !job_full && !(st_nxt == ST_IDLE && end_blk)) begin
          if (cur_ch == stereo) done_r <= done_inc;
          nch_r <= stereo ? ~cur_ch : 1'b0;
        end
        if (st_nxt == ST_IDLE) begin
          if (end_blk) begin
            pos_r  <= '0;
            done_r <= '0;
            nch_r  <= 1'b0;
          end else begin
            pos_r <= pos_r + 13'd1;
          end
        end
      end
    end
  end
endmodule

// ===== hdl/msadpcm_back.sv =====
// Sample engine: prediction, adaptation and history, one shared multiplier.
module msadpcm_back #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_empty,
  input  msadpcm_pkg::job_t     job,
  output logic                  job_pop,
  output logic                  engine_idle,
  input  logic [4:0]            sel0,
  input  logic [4:0]            sel1,
  output logic [$clog2(TABLE_DEPTH)-1:0] coef_raddr,
  input  logic signed [15:0]    coef1,
  input  logic signed [15:0]    coef2,
  input  logic [15:0]           hdr_delta,
  input  logic                  hdr_delta_we,
  input  logic                  hdr_ch,
  input  logic                  hdr_h1_we,
  input  logic                  hdr_h2_we,
  input  logic [15:0]           hdr_value,
  output logic                  out_valid,
  output msadpcm_pkg::out_item_t out_data,
  input  logic                  out_take
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_M1   = 6'b000100,
    S_M2   = 6'b001000,
    S_M3   = 6'b010000,
    S_OUT  = 6'b100000
  } st_t;

  st_t st_r, st_nxt;
  logic signed [15:0] d_r [2];
  logic signed [15:0] h1_r [2];
  logic signed [15:0] h2_r [2];
  logic signed [37:0] acc_r;
  msadpcm_pkg::job_t  job_r;
  logic               ov_r;
  msadpcm_pkg::out_item_t od_r;

  logic signed [16:0] ma;
  logic signed [16:0] mb;
  logic signed [33:0] mp;
  logic               ch;
  logic signed [4:0]  code_s;
  logic signed [37:0] pred;
  logic signed [37:0] v;
  logic signed [15:0] vs;
  logic signed [31:0] mp32;
  logic signed [31:0] nd;
  logic signed [15:0] nds;

  assign ch = job_r.channel;
  assign coef_raddr = $clog2(TABLE_DEPTH)'(ch ? sel1 : sel0);
  assign code_s = {job_r.nibble[3], job_r.nibble};

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_r)
      S_M1: begin ma = 17'(h1_r[ch]); mb = 17'(coef1); end
      S_M2: begin ma = 17'(h2_r[ch]); mb = 17'(coef2); end
      S_M3: begin
        ma = 17'(d_r[ch]);
        mb = $signed({7'b0, msadpcm_pkg::adapt_lookup(job_r.nibble)});
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign mp = ma * mb;
  assign mp32 = $signed(mp[31:0]);

  always_comb begin
    // truncation toward zero
    pred = acc_r >>> 8;
    if (acc_r < 0 && acc_r[7:0] != 8'd0) pred = pred + 38'sd1;
    v = pred + 38'(d_r[ch]) * 38'(code_s);
    if (v > 38'sd32767) vs = msadpcm_pkg::SAT_MAX;
    else if (v < -38'sd32768) vs = msadpcm_pkg::SAT_MIN;
    else vs = v[15:0];
    nd = mp32 >>> 8;
    if (mp32 < 0 && mp32[7:0] != 8'd0) nd = nd + 32'sd1;
    if (nd < 32'sd16) nds = $signed(msadpcm_pkg::DELTA_MIN);
    else if (nd > 32'sd32767) nds = msadpcm_pkg::SAT_MAX;
    else nds = nd[15:0];
  end

  assign job_pop     = (st_r == S_IDLE) && !job_empty;
  assign engine_idle = (st_r == S_IDLE);
  assign out_valid   = ov_r;
  assign out_data    = od_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (!job_empty) st_nxt = (job.kind == msadpcm_pkg::JOB_DECODE) ? S_RD : S_OUT;
      S_RD:   st_nxt = S_M1;
      S_M1:   st_nxt = S_M2;
      S_M2:   st_nxt = S_M3;
      S_M3:   st_nxt = S_OUT;
      S_OUT:  if (!ov_r || out_take) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_pop) job_r <= job;
    else if (st_r == S_M3) job_r.value <= vs;
    if (st_r == S_M1) acc_r <= 38'(mp);
    if (st_r == S_M2) acc_r <= acc_r + 38'(mp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      od_r <= '0;
      for (int i = 0; i < 2; i++) begin
        d_r[i] <= '0; h1_r[i] <= '0; h2_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (hdr_delta_we) d_r[hdr_ch] <= hdr_delta;
      if (hdr_h1_we) h1_r[hdr_ch] <= hdr_value;
      if (hdr_h2_we) h2_r[hdr_ch] <= hdr_value;
      if (st_r == S_M3) begin
        d_r[ch]  <= nds;
        h2_r[ch] <= h1_r[ch];
        h1_r[ch] <= vs;
      end
      if (st_r == S_OUT && (!ov_r || out_take)) begin
        ov_r <= 1'b1;
        od_r.sample     <= job_r.value;
        od_r.channel    <= job_r.channel;
        od_r.last       <= job_r.last;
        od_r.block_done <= job_r.block_done;
        od_r.bad_index  <= job_r.bad_index;
      end else if (out_take) begin
        ov_r <= 1'b0;
      end
    end
  end
endmodule

// ===== tb/sv/msadpcm_checker.sv =====
// Scoreboard for the ADPCM block decoder: predicts decoded samples and compares them.
module msadpcm_checker
  import msadpcm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic                       in_full,
  input  in_item_t                   in_data,
  input  logic                       out_empty,
  input  logic                       out_pop,
  input  out_item_t                  out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                cfg_wdata,
  output int                         pending,
  output int                         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_COEFF = 32;
  localparam int BLOCK_CAP = 4096;
  localparam int ADAPT_TAB [16] = '{230, 230, 230, 230, 307, 409, 512, 614,
                                    768, 614, 512, 409, 307, 230, 230, 230};

  // Coefficient table and per-channel decode state.
  logic signed [15:0] coef_one [NUM_COEFF];
  logic signed [15:0] coef_two [NUM_COEFF];
  logic [4:0]         pred_sel [2];
  logic signed [15:0] step_sz  [2];
  logic signed [15:0] hist_one [2];
  logic signed [15:0] hist_two [2];
  logic               bad_sel  [2];
  int unsigned        byte_pos;
  int unsigned        frames_done;
  logic [7:0]         low_hold;
  logic               nib_ch;

  // Register copies.
  logic [1:0]  num_ch_reg;
  logic [12:0] blk_bytes_reg;
  logic [13:0] spb_reg;
  logic [5:0]  ncoef_reg;

  out_item_t pcm_due [$];

  assign pending = pcm_due.size();

  function automatic logic signed [15:0] decode_nibble(input int c, input logic [3:0] nib);
    longint s1, s2, c1, c2, pred, code, d, v, nd;
    s1 = hist_one[c];
    s2 = hist_two[c];
    c1 = coef_one[pred_sel[c]];
    c2 = coef_two[pred_sel[c]];
    pred = (s1 * c1 + s2 * c2) / 256;
    code = nib[3] ? longint'(nib) - 16 : longint'(nib);
    d = step_sz[c];
    v = pred + d * code;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    nd = d * ADAPT_TAB[nib] / 256;
    if (nd < 16) nd = 16;
    if (nd > 32767) nd = 32767;
    step_sz[c] = nd[15:0];
    hist_two[c] = hist_one[c];
    hist_one[c] = v[15:0];
    return v[15:0];
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    out_item_t   res [$];
    out_item_t   r;
    int unsigned nch, len, cnt, k, grp, w, c;
    logic [15:0] word;
    logic [3:0]  nib;
    nch = (num_ch_reg >= 2) ? 2 : 1;
    len = blk_bytes_reg;
    if (len > BLOCK_CAP) len = BLOCK_CAP;
    if (len == 0) len = 1;
    if (byte_pos < nch) begin
      cnt = ncoef_reg;
      if (cnt > NUM_COEFF) cnt = NUM_COEFF;
      c = byte_pos & 1;
      if (b < cnt) begin
        pred_sel[c] = b[4:0];
        bad_sel[c] = 1'b0;
      end else begin
        pred_sel[c] = '0;
        bad_sel[c] = 1'b1;
      end
    end else if (byte_pos < 7 * nch) begin
      k = byte_pos - nch;
      grp = k / (2 * nch);
      w = k % (2 * nch);
      c = (w >> 1) & 1;
      if (!w[0]) begin
        low_hold = b;
      end else begin
        word = {b, low_hold};
        if (grp == 0) begin
          step_sz[c] = word;
        end else begin
          if (grp == 1) hist_one[c] = word;
          else hist_two[c] = word;
          r = '0;
          r.sample = word;
          r.channel = c[0];
          r.bad_index = bad_sel[c];
          if (c == nch - 1) begin
            frames_done = grp;
            if (grp == 2 && spb_reg <= 2) r.block_done = 1'b1;
          end
          res.push_back(r);
        end
      end
    end else begin
      for (int h = 0; h < 2; h++) begin
        nib = (h == 0) ? b[7:4] : b[3:0];
        c = (nch == 2) ? nib_ch : 0;
        if (c == 0 && frames_done >= spb_reg) continue;
        r = '0;
        r.sample = decode_nibble(c, nib);
        r.channel = c[0];
        r.bad_index = bad_sel[c];
        if (c == nch - 1) begin
          if (frames_done < 14'h3fff) frames_done++;
          if (frames_done >= spb_reg) r.block_done = 1'b1;
        end
        nib_ch = (nch == 2) ? ~c[0] : 1'b0;
        res.push_back(r);
      end
    end
    if (byte_pos + 1 >= len) begin
      if (res.size() > 0) res[res.size()-1].block_done = 1'b1;
      byte_pos = 0;
      frames_done = 0;
      nib_ch = 1'b0;
    end else begin
      byte_pos++;
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) pcm_due.push_back(res[i]);
  endtask

  task automatic compare_sample(input out_item_t got);
    out_item_t want;
    if (pcm_due.size() == 0) begin
      $error("unexpected sample %0d on channel %0d", got.sample, got.channel);
      fail_count++;
      return;
    end
    want = pcm_due.pop_front();
    if (got.sample !== want.sample) begin
      $error("sample: expected %0d, got %0d", want.sample, got.sample);
      fail_count++;
    end
    if (got.channel !== want.channel) begin
      $error("channel: expected %0d, got %0d", want.channel, got.channel);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
    if (got.block_done !== want.block_done) begin
      $error("block_done: expected %0d, got %0d", want.block_done, got.block_done);
      fail_count++;
    end
    if (got.bad_index !== want.bad_index) begin
      $error("bad_index: expected %0d, got %0d", want.bad_index, got.bad_index);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      pcm_due.delete();
      for (int c = 0; c < 2; c++) begin
        pred_sel[c] = '0;
        step_sz[c] = '0;
        hist_one[c] = '0;
        hist_two[c] = '0;
        bad_sel[c] = 1'b0;
      end
      byte_pos = 0;
      frames_done = 0;
      low_hold = '0;
      nib_ch = 1'b0;
      num_ch_reg = 2'd1;
      blk_bytes_reg = 13'd256;
      spb_reg = 14'd500;
      ncoef_reg = 6'd7;
    end else begin
      // A result popped now always stems from an earlier transaction.
      if (out_pop && !out_empty) compare_sample(out_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CHANNEL_COUNT:     num_ch_reg = cfg_wdata[1:0];
          REG_BLOCK_BYTES:       blk_bytes_reg = cfg_wdata[12:0];
          REG_SAMPLES_PER_BLOCK: spb_reg = cfg_wdata[13:0];
          REG_COEFF_COUNT:       ncoef_reg = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        if (in_data.op == OP_LOAD_COEFF) begin
          coef_one[in_data.coeff_index] = in_data.coeff_first;
          coef_two[in_data.coeff_index] = in_data.coeff_second;
        end else begin
          decode_byte(in_data.data_byte);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: drives stimulus into the ADPCM block decoder and reports the verdict.
module tb_top;
  import msadpcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000; // idle cycles before the watchdog fires
  localparam int SETTLE = 40;         // cycles for a result-free byte to drain
  localparam int NUM_PHASES = 9;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  in_item_t             in_data;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;
  int                   pending;
  int                   fail_count;

  // Per-phase settings: channels, block bytes, samples per block, coeff count,
  // data transactions. Raw values outside the documented ranges are included
  // on purpose: channel 0 and 3, block length 0, coeff count 0 and above 32.
  int ph_ch    [NUM_PHASES] = '{1, 2, 1, 3, 0, 2, 1, 2, 1};
  int ph_bytes [NUM_PHASES] = '{8, 16, 24, 5, 0, 64, 4096, 8191, 40};
  int ph_spb   [NUM_PHASES] = '{2, 8, 30, 500, 2, 100, 8192, 16383, 60};
  int ph_coef  [NUM_PHASES] = '{1, 32, 7, 33, 0, 4, 16, 63, 2};
  int ph_items [NUM_PHASES] = '{24, 200, 200, 100, 40, 300, 250, 150, 200};

  int burst_left;
  int pops_seen;

  ms_adpcm_block_decoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  msadpcm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sender side. Every input transaction goes through here; push stays high across
  // a burst and drops only when the burst runs out, then a random gap may follow.
  task automatic push_item(input in_item_t it);
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    burst_left--;
    if (burst_left <= 0) begin
      in_push <= 1'b0;
      // one burst in four is followed by no gap at all
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic load_coeff(input logic [4:0] idx, input logic [15:0] c1,
                            input logic [15:0] c2);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    it.op = OP_LOAD_COEFF;
    it.coeff_index = idx;
    it.coeff_first = c1;
    it.coeff_second = c2;
    push_item(it);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every predicted sample has been popped, then give a byte that
  // produces nothing time to leave the pipeline.
  task automatic drain;
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One phase: program all four registers, then stream bytes that follow the
  // block layout so that most blocks get well past the header.
  task automatic run_phase(input int p);
    int        nch, len, ncoef, pos;
    logic [7:0] b;
    in_item_t  it;
    nch = (ph_ch[p] >= 2) ? 2 : 1;
    len = (ph_bytes[p] == 0) ? 1 : ph_bytes[p];
    ncoef = (ph_coef[p] > 32) ? 32 : ph_coef[p];
    write_reg(REG_CHANNEL_COUNT, 16'(ph_ch[p]) | (16'($urandom) & 16'hfffc));
    write_reg(REG_BLOCK_BYTES, 16'(ph_bytes[p]));
    write_reg(REG_SAMPLES_PER_BLOCK, 16'(ph_spb[p]));
    write_reg(REG_COEFF_COUNT, 16'(ph_coef[p]));
    pos = 0;
    for (int n = 0; n < ph_items[p]; n++) begin
      // occasional coefficient reload; every entry is already written
      if ($urandom_range(0, 19) == 0)
        load_coeff(5'($urandom), 16'($urandom), 16'($urandom));
      b = 8'($urandom);
      if (pos < nch) begin
        // predictor index: mostly valid, sometimes out of range
        if (ncoef > 0 && $urandom_range(0, 4) != 0) b = 8'($urandom_range(0, ncoef - 1));
      end else if (pos < 3 * nch && pos[0] != nch[0] && $urandom_range(0, 1) == 0) begin
        // keep half of the header deltas small in magnitude
        b = 8'($urandom_range(0, 1));
      end
      it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
      it.op = OP_DATA_BYTE;
      it.data_byte = b;
      push_item(it);
      pos = (pos + 1 >= len) ? 0 : pos + 1;
    end
    drain();
  endtask

  // Stimulus.
  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    burst_left = 4;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Fill the whole table first, with extreme pairs at the low entries, so
    // that no predictor index can ever reach an unwritten entry.
    load_coeff(5'd0, 16'h7fff, 16'h8000);
    load_coeff(5'd1, 16'h8000, 16'h7fff);
    load_coeff(5'd2, 16'd256, 16'd0);
    load_coeff(5'd3, 16'hffff, 16'hffff);
    for (int i = 4; i < 32; i++) load_coeff(5'(i), 16'($urandom), 16'($urandom));
    drain();
    for (int p = 0; p < NUM_PHASES; p++) run_phase(p);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver side: it switches between random stall patterns, and once, after
  // 600 pops, it holds off long enough to back the block up.
  initial begin
    int mode;
    int hold;
    int cyc;
    bit held;
    pops_seen = 0;
    mode = 0;
    hold = 0;
    cyc = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) pops_seen++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      cyc++;
      if (!held && pops_seen >= 600) begin
        held = 1'b1;
        hold = 500;
      end
      if (hold > 0) begin
        hold--;
        out_pop <= 1'b0;
      end else begin
        case (mode)
          0:       out_pop <= 1'b1;
          1:       out_pop <= ($urandom_range(0, 1) == 0);
          2:       out_pop <= ($urandom_range(0, 4) == 0);
          default: out_pop <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when no transaction of any kind happens for too long.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

// ===== ms_adpcm_block_decoder_top.f =====
hdl/msadpcm_pkg.sv
hdl/msadpcm_ram.sv
hdl/msadpcm_fifo.sv
hdl/msadpcm_front.sv
hdl/msadpcm_back.sv
hdl/ms_adpcm_block_decoder_top.sv
tb/sv/msadpcm_checker.sv
tb/sv/tb_top.sv
